### rtl/rmva_pkg.sv
// shared types and constants for the running mean and variance accumulator
`default_nettype none

package rmva_pkg;

    // data widths fixed by the beat formats
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned VAR_W   = 48;
    localparam int unsigned COUNT_W = 24;
    localparam int unsigned DIMS_W  = 5;
    localparam int unsigned IDX_OUT_W = 4;

    // shared adder width and step counts of the serial divide and multiply
    localparam int unsigned ALU_W      = 64;
    localparam int unsigned QUO_W      = 48;
    localparam int unsigned STEP_W     = 6;
    localparam int unsigned MEAN_STEPS = 32;
    localparam int unsigned MUL_STEPS  = 32;
    localparam int unsigned VAR_STEPS  = 48;

    localparam int unsigned MAX_DIMS_DEF = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [VAR_W-1:0]   VAR_MAX   = {VAR_W{1'b1}};

    // apb register map, selected by paddr[2]
    localparam int unsigned PADDR_W = 3;
    localparam logic REG_DIMS = 1'b0;
    localparam logic REG_KEEP = 1'b1;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sample_value;
        logic                      restart;
    } in_beat_t;

    typedef struct packed {
        logic [IDX_OUT_W-1:0]      dim_index;
        logic signed [VALUE_W-1:0] mean_value;
        logic [VAR_W-1:0]          variance_value;
        logic [COUNT_W-1:0]        samples_seen;
        logic                      sample_done;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV_MEAN,
        ST_MEAN_FIN,
        ST_MUL_SET,
        ST_MUL,
        ST_VAR_SET,
        ST_DIV_VAR,
        ST_VAR_FIN,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

### rtl/running_mean_variance_accumulator.sv
// top level: per-dimension running mean and population variance (welford update)
`default_nettype none

// Per-dimension running mean and variance of a stream of Q16.16 target values.
// Values arrive one dimension per input beat, dimension 0 first; after the last
// dimension (dims_in_use, register 0) the sample count steps up, saturating at
// 2^24-1, and restart on a beat starts a new leaf with count 1. Each input beat
// gives one result beat with the dimension, the new mean (Q16.16), the new
// variance (unsigned Q32.16, 0 when keep_variance, register 1, is clear), the
// sample number and a last-dimension flag. The block handles one beat at a time:
// s_ready is high only while idle. Only the mean is worked out when variance is
// off or for the first sample of a leaf. The work runs on one shared 64-bit adder
// that runs a radix-2 restoring divide by the count (32 steps for the mean, 48
// for the variance) and a 32-step shift-add multiply, besides the read, setup
// and finish states and idle. A finished result waits in the output register, and
// a new beat is taken while it waits; the next result then stalls in the finish
// state until that one is taken. Per-dimension statistics sit in a small memory
// whose entries read as zero until first written after reset, so no clearing
// pass is needed.
module running_mean_variance_accumulator #(
    parameter int unsigned MAX_DIMS = rmva_pkg::MAX_DIMS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input beats
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire rmva_pkg::in_beat_t            s_data,
    // result beats
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output rmva_pkg::out_beat_t                m_data,
    // apb configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rmva_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int unsigned IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int unsigned DW    = IDX_W + 1;
    localparam int unsigned CW    = (DW > rmva_pkg::DIMS_W) ? DW : rmva_pkg::DIMS_W;

    localparam int unsigned VW  = rmva_pkg::VALUE_W;
    localparam int unsigned VRW = rmva_pkg::VAR_W;
    localparam int unsigned NW  = rmva_pkg::COUNT_W;
    localparam int unsigned AW  = rmva_pkg::ALU_W;
    localparam int unsigned QW  = rmva_pkg::QUO_W;
    localparam int unsigned SW  = rmva_pkg::STEP_W;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [rmva_pkg::DIMS_W-1:0] dims_reg;
    logic                        keep_reg;
    logic                        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg <= rmva_pkg::DIMS_W'(1);
            keep_reg <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                rmva_pkg::REG_DIMS: dims_reg <= pwdata[rmva_pkg::DIMS_W-1:0];
                rmva_pkg::REG_KEEP: keep_reg <= pwdata[0];
                default:            dims_reg <= dims_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            rmva_pkg::REG_DIMS: prdata = 32'(dims_reg);
            rmva_pkg::REG_KEEP: prdata = 32'(keep_reg);
            default:            prdata = '0;
        endcase
    end

    // effective dimension count: 0 acts as 1, above MAX_DIMS acts as MAX_DIMS
    logic [CW-1:0] dims_cfg;
    logic [CW-1:0] dims_eff;

    assign dims_cfg = CW'(dims_reg);
    always_comb begin
        if (dims_cfg == '0) begin
            dims_eff = CW'(1);
        end else if (dims_cfg > CW'(MAX_DIMS)) begin
            dims_eff = CW'(MAX_DIMS);
        end else begin
            dims_eff = dims_cfg;
        end
    end

    // ---------------------------------------------------------------
    // leaf state: dimension pointer and sample count
    // ---------------------------------------------------------------
    logic [IDX_W-1:0] ptr_reg;
    logic [NW-1:0]    count_reg;

    // per-beat working registers
    rmva_pkg::state_t state_reg, state_next;
    logic signed [VW-1:0] x_reg;
    logic [IDX_W-1:0]     d_reg;
    logic [NW-1:0]        n_reg;
    logic                 done_reg;
    logic                 neg_reg;
    logic [VW-1:0]        magold_reg;
    logic [VW-1:0]        magnew_reg;
    logic signed [VW-1:0] mnew_reg;
    logic [VRW-1:0]       varnew_reg;
    logic [QW-1:0]        q_reg;
    logic [NW-1:0]        rem_reg;
    logic [AW-1:0]        prod_reg;
    logic [SW-1:0]        step_reg;

    // memory read data
    logic signed [VW-1:0] mean_rd_reg;
    logic [VRW-1:0]       var_rd_reg;
    logic                 vld_rd_reg;

    // output register
    logic                 m_valid_reg;
    rmva_pkg::out_beat_t  m_data_reg;

    logic             accept;
    logic             out_free;
    logic             out_load;
    logic [IDX_W-1:0] d_in;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign d_in     = s_data.restart ? '0 : ptr_reg;

    // ---------------------------------------------------------------
    // statistics memory, entries read as zero until written
    // ---------------------------------------------------------------
    logic signed [VW-1:0] mean_mem [MAX_DIMS];
    logic [VRW-1:0]       var_mem  [MAX_DIMS];
    logic [MAX_DIMS-1:0]  vld_reg;

    always_ff @(posedge aclk) begin
        if (out_load) begin
            mean_mem[d_reg] <= mnew_reg;
            var_mem[d_reg]  <= varnew_reg;
        end
        if (accept) begin
            mean_rd_reg <= mean_mem[d_in];
            var_rd_reg  <= var_mem[d_in];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            vld_rd_reg <= 1'b0;
        end else begin
            if (out_load) begin
                vld_reg[d_reg] <= 1'b1;
            end
            if (accept) begin
                vld_rd_reg <= vld_reg[d_in];
            end
        end
    end

    logic signed [VW-1:0] m_old;
    logic [VRW-1:0]       v_old;

    assign m_old = vld_rd_reg ? mean_rd_reg : '0;
    assign v_old = vld_rd_reg ? var_rd_reg  : '0;

    // ---------------------------------------------------------------
    // shared adder: divide trial subtract or multiply accumulate
    // ---------------------------------------------------------------
    logic [AW-1:0] alu_a, alu_b, alu_res;
    logic          alu_sub;

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg) inside
            rmva_pkg::ST_DIV_MEAN, rmva_pkg::ST_DIV_VAR: begin
                alu_a   = AW'({rem_reg, q_reg[QW-1]});
                alu_b   = AW'(n_reg);
                alu_sub = 1'b1;
            end
            rmva_pkg::ST_MUL: begin
                alu_a = {prod_reg[AW-2:0], 1'b0};
                alu_b = q_reg[QW-1] ? AW'(magnew_reg) : '0;
            end
            default: begin
                alu_sub = 1'b0;
            end
        endcase
        alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    end

    // restoring divide step: the trial fits when the difference is not negative
    logic          trial_ok;
    logic [NW-1:0] rem_step;

    assign trial_ok = !alu_res[AW-1];
    assign rem_step = trial_ok ? alu_res[NW-1:0] : {rem_reg[NW-2:0], q_reg[QW-1]};

    // ---------------------------------------------------------------
    // arithmetic around the shared unit
    // ---------------------------------------------------------------
    // x - old mean, and its magnitude
    logic signed [VW:0] diff_old;
    logic [VW:0]        diff_old_abs;
    assign diff_old     = (VW+1)'(x_reg) - (VW+1)'(m_old);
    assign diff_old_abs = diff_old[VW] ? -diff_old : diff_old;

    // new mean from the signed quotient
    logic signed [VW:0]   qm_signed;
    logic signed [VW+1:0] mean_sum;
    logic signed [VW-1:0] m_new;
    assign qm_signed = neg_reg ? -$signed({1'b0, q_reg[VW-1:0]})
                               : $signed({1'b0, q_reg[VW-1:0]});
    assign mean_sum  = (VW+2)'(m_old) + (VW+2)'(qm_signed);
    assign m_new     = mean_sum[VW-1:0];

    // x - new mean magnitude for the product
    logic signed [VW:0] diff_new;
    logic [VW:0]        diff_new_abs;
    assign diff_new     = (VW+1)'(x_reg) - (VW+1)'(mnew_reg);
    assign diff_new_abs = diff_new[VW] ? -diff_new : diff_new;

    // t - old variance, with t the product shifted down by 16
    logic [VRW-1:0]      t_val;
    logic signed [VRW:0] dvar;
    logic [VRW:0]        dvar_abs;
    assign t_val    = prod_reg[AW-1:AW-VRW];
    assign dvar     = $signed({1'b0, t_val}) - $signed({1'b0, v_old});
    assign dvar_abs = dvar[VRW] ? -dvar : dvar;

    // new variance from the signed quotient, clamped to the stored range
    logic signed [VRW:0]   qv_signed;
    logic signed [VRW+1:0] var_sum;
    logic [VRW-1:0]        v_new;
    assign qv_signed = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
    assign var_sum   = (VRW+2)'($signed({1'b0, v_old})) + (VRW+2)'(qv_signed);
    always_comb begin
        if (var_sum < 0) begin
            v_new = '0;
        end else if (var_sum > (VRW+2)'($signed({1'b0, rmva_pkg::VAR_MAX}))) begin
            v_new = rmva_pkg::VAR_MAX;
        end else begin
            v_new = var_sum[VRW-1:0];
        end
    end

    logic var_wanted;
    assign var_wanted = keep_reg && (n_reg != NW'(1));

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    logic last_step;

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        out_load   = 1'b0;
        last_step  = 1'b0;
        unique case (state_reg)
            rmva_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = rmva_pkg::ST_READ;
                end
            end
            rmva_pkg::ST_READ: begin
                state_next = rmva_pkg::ST_DIV_MEAN;
            end
            rmva_pkg::ST_DIV_MEAN: begin
                last_step = (step_reg == SW'(rmva_pkg::MEAN_STEPS - 1));
                if (last_step) begin
                    state_next = rmva_pkg::ST_MEAN_FIN;
                end
            end
            rmva_pkg::ST_MEAN_FIN: begin
                state_next = var_wanted ? rmva_pkg::ST_MUL_SET : rmva_pkg::ST_FINISH;
            end
            rmva_pkg::ST_MUL_SET: begin
                state_next = rmva_pkg::ST_MUL;
            end
            rmva_pkg::ST_MUL: begin
                last_step = (step_reg == SW'(rmva_pkg::MUL_STEPS - 1));
                if (last_step) begin
                    state_next = rmva_pkg::ST_VAR_SET;
                end
            end
            rmva_pkg::ST_VAR_SET: begin
                state_next = rmva_pkg::ST_DIV_VAR;
            end
            rmva_pkg::ST_DIV_VAR: begin
                last_step = (step_reg == SW'(rmva_pkg::VAR_STEPS - 1));
                if (last_step) begin
                    state_next = rmva_pkg::ST_VAR_FIN;
                end
            end
            rmva_pkg::ST_VAR_FIN: begin
                state_next = rmva_pkg::ST_FINISH;
            end
            rmva_pkg::ST_FINISH: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = rmva_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rmva_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rmva_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------------------------------------------------------
    // leaf state update
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg   <= '0;
            count_reg <= NW'(1);
        end else if (out_load) begin
            if (done_reg) begin
                ptr_reg   <= '0;
                count_reg <= (n_reg == rmva_pkg::COUNT_MAX) ? n_reg : n_reg + NW'(1);
            end else begin
                ptr_reg   <= d_reg + IDX_W'(1);
                count_reg <= n_reg;
            end
        end
    end

    // ---------------------------------------------------------------
    // datapath registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            rmva_pkg::ST_IDLE: begin
                if (s_valid) begin
                    // restart applies before this value is processed
                    x_reg    <= s_data.sample_value;
                    d_reg    <= d_in;
                    n_reg    <= s_data.restart ? NW'(1) : count_reg;
                    done_reg <= (CW'(d_in) + CW'(1)) >= dims_eff;
                end
            end
            rmva_pkg::ST_READ: begin
                neg_reg    <= diff_old[VW];
                magold_reg <= diff_old_abs[VW-1:0];
                q_reg      <= {diff_old_abs[VW-1:0], (QW-VW)'(0)};
                rem_reg    <= '0;
                step_reg   <= '0;
            end
            rmva_pkg::ST_DIV_MEAN, rmva_pkg::ST_DIV_VAR: begin
                rem_reg  <= rem_step;
                q_reg    <= {q_reg[QW-2:0], trial_ok};
                step_reg <= step_reg + SW'(1);
            end
            rmva_pkg::ST_MEAN_FIN: begin
                mnew_reg   <= m_new;
                varnew_reg <= '0;
            end
            rmva_pkg::ST_MUL_SET: begin
                magnew_reg <= diff_new_abs[VW-1:0];
                q_reg      <= {magold_reg, (QW-VW)'(0)};
                prod_reg   <= '0;
                step_reg   <= '0;
            end
            rmva_pkg::ST_MUL: begin
                prod_reg <= alu_res;
                q_reg    <= {q_reg[QW-2:0], 1'b0};
                step_reg <= step_reg + SW'(1);
            end
            rmva_pkg::ST_VAR_SET: begin
                neg_reg  <= dvar[VRW];
                q_reg    <= dvar_abs[QW-1:0];
                rem_reg  <= '0;
                step_reg <= '0;
            end
            rmva_pkg::ST_VAR_FIN: begin
                varnew_reg <= v_new;
            end
            default: begin
                step_reg <= step_reg;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // output register, holds a result until the sink takes the beat
    // ---------------------------------------------------------------
    logic [31:0] d_ext;
    assign d_ext = 32'(d_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.dim_index      <= d_ext[rmva_pkg::IDX_OUT_W-1:0];
            m_data_reg.mean_value     <= mnew_reg;
            m_data_reg.variance_value <= varnew_reg;
            m_data_reg.samples_seen   <= n_reg;
            m_data_reg.sample_done    <= done_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

### rtl/rmva_checker.sv
// port-level checks for the running mean and variance accumulator
`default_nettype none

module rmva_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire rmva_pkg::out_beat_t m_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat dropped or changed while stalled");

    // one beat in work at a time
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a beat is in work");

    // first sample of a leaf has no spread
    a_first_var_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.samples_seen == 24'd1) |-> (m_data.variance_value == 48'd0))
        else $error("nonzero variance on the first sample");

    // sample count never wraps to zero
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.samples_seen != 24'd0))
        else $error("sample count reads zero");

endmodule

bind running_mean_variance_accumulator rmva_checker u_rmva_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

### dv/running_mean_variance_accumulator_tb.sv
// testbench for the running mean and variance accumulator: welford predictor and stream checks
module running_mean_variance_accumulator_tb;
    import rmva_pkg::*;

    localparam int N_DIMS       = MAX_DIMS_DEF;
    localparam int PHASE_VALUES = 125;

    // per-dimension welford statistics as the block should hold them, plus the
    // queue of result beats still owed by the block
    class welford_tracker;
        logic [DIMS_W-1:0]         dims_reg;
        logic                      keep_reg;
        logic signed [VALUE_W-1:0] means [N_DIMS];
        logic [VAR_W-1:0]          variances [N_DIMS];
        int unsigned               dim_ptr;
        logic [COUNT_W-1:0]        count;
        out_beat_t                 expected_stats [$];
        int                        errors;

        function new();
            dims_reg = 1;
            keep_reg = 0;
            dim_ptr  = 0;
            count    = 1;
            errors   = 0;
            foreach (means[i]) begin
                means[i]     = '0;
                variances[i] = '0;
            end
        endfunction

        // accepted input beat: update the statistics and queue the result
        function void take_value(in_beat_t b);
            int unsigned      dims, d;
            longint           x, m_old, m_new, n, diff_old, diff_new, v, t, r;
            longint unsigned  prod;
            logic [VAR_W-1:0] var_new;
            bit               done;
            out_beat_t        e;
            dims = dims_reg;
            if (dims == 0) dims = 1;
            if (dims > N_DIMS) dims = N_DIMS;
            if (b.restart) begin
                count   = 1;
                dim_ptr = 0;
            end
            d     = (dim_ptr >= N_DIMS) ? N_DIMS - 1 : dim_ptr;
            done  = (d + 1 >= dims);
            n     = longint'(count);
            x     = longint'($signed(b.sample_value));
            m_old = longint'(means[d]);
            m_new = m_old + (x - m_old) / n;
            var_new = '0;
            if (keep_reg && n > 1) begin
                diff_old = x - m_old;
                diff_new = x - m_new;
                if (diff_old < 0) diff_old = -diff_old;
                if (diff_new < 0) diff_new = -diff_new;
                prod = $unsigned(diff_old) * $unsigned(diff_new);
                t = longint'(prod >> 16);
                v = longint'(variances[d]);
                r = v + (t - v) / n;
                if (r < 0) r = 0;
                if (r > longint'(VAR_MAX)) r = longint'(VAR_MAX);
                var_new = r[VAR_W-1:0];
            end
            means[d]     = m_new[VALUE_W-1:0];
            variances[d] = var_new;
            e.dim_index      = d[IDX_OUT_W-1:0];
            e.mean_value     = m_new[VALUE_W-1:0];
            e.variance_value = var_new;
            e.samples_seen   = count;
            e.sample_done    = done;
            expected_stats.push_back(e);
            if (done) begin
                dim_ptr = 0;
                if (count != COUNT_MAX) count++;
            end else begin
                dim_ptr = d + 1;
            end
        endfunction

        // accepted result beat against the oldest owed one
        function void check_result(out_beat_t got);
            out_beat_t want;
            if (expected_stats.size() == 0) begin
                $error("result beat with nothing pending: dim_index %0d mean_value %0d",
                       got.dim_index, got.mean_value);
                errors++;
                return;
            end
            want = expected_stats.pop_front();
            if (got.dim_index !== want.dim_index) begin
                $error("dim_index: expected %0d, got %0d", want.dim_index, got.dim_index);
                errors++;
            end
            if (got.mean_value !== want.mean_value) begin
                $error("mean_value: expected %0d, got %0d", want.mean_value, got.mean_value);
                errors++;
            end
            if (got.variance_value !== want.variance_value) begin
                $error("variance_value: expected %0d, got %0d",
                       want.variance_value, got.variance_value);
                errors++;
            end
            if (got.samples_seen !== want.samples_seen) begin
                $error("samples_seen: expected %0d, got %0d",
                       want.samples_seen, got.samples_seen);
                errors++;
            end
            if (got.sample_done !== want.sample_done) begin
                $error("sample_done: expected %0d, got %0d", want.sample_done, got.sample_done);
                errors++;
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    in_beat_t            s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    out_beat_t           m_data;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;

    // idle odds in percent, changed per phase
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    welford_tracker tracker = new();

    running_mean_variance_accumulator #(
        .MAX_DIMS (N_DIMS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: random back-pressure, held low through reset
    always @(posedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= sink_stall_pct);
    end

    // every result beat is checked at the edge that takes it
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) tracker.check_result(m_data);
    end

    // apb write: setup phase, access phase, then psel and penable dropped
    task automatic apb_write(input logic reg_sel, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        if (reg_sel == REG_DIMS) tracker.dims_reg = val[DIMS_W-1:0];
        else tracker.keep_reg = val[0];
    endtask

    // one input beat; valid stays high afterward until the caller lowers it
    // or the next call idles, so back-to-back beats need no extra edge
    task automatic send_value(input logic [VALUE_W-1:0] value, input logic restart_flag);
        in_beat_t b;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        b.sample_value = value;
        b.restart      = restart_flag;
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        tracker.take_value(b);
    endtask

    task automatic wait_drained();
        while (tracker.expected_stats.size() != 0) @(posedge aclk);
    endtask

    // mostly values scattered around the leaf center, some full-range and extremes
    function automatic logic [VALUE_W-1:0] pick_value(input logic [VALUE_W-1:0] center);
        int noise;
        int pick;
        pick  = $urandom_range(99);
        noise = int'($urandom()) >>> $urandom_range(8, 31);
        if (pick < 70) return center + noise;
        if (pick < 88) return $urandom();
        case ($urandom_range(4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
        endcase
    endfunction

    initial begin
        int               sent;
        int               leaf_left;
        logic [31:0]      dims_val;
        logic [VALUE_W-1:0] center;
        logic             rs;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // ---- directed part ----
        apb_write(REG_KEEP, 32'd1);
        apb_write(REG_DIMS, 32'd4);
        // first sample of a leaf: mean takes the value, variance stays zero
        send_value(32'h7FFF_FFFF, 1'b1);
        send_value(32'h8000_0000, 1'b0);
        send_value(32'h0000_0000, 1'b0);
        send_value(32'hFFFF_FFFF, 1'b0);
        // opposite extremes on the first two dimensions: widest differences, largest products
        send_value(32'h8000_0000, 1'b0);
        send_value(32'h7FFF_FFFF, 1'b0);
        send_value(32'h0000_0001, 1'b0);
        send_value(32'h0001_0000, 1'b0);
        // two beats into the third sample
        send_value(32'h7FFF_FFFF, 1'b0);
        send_value(32'h8000_0000, 1'b0);
        s_valid <= 1'b0;
        wait_drained();
        // dimension count lowered mid-sample: pointer past the end closes the sample
        apb_write(REG_DIMS, 32'd1);
        send_value(32'h1234_5678, 1'b0);
        s_valid <= 1'b0;
        wait_drained();
        // zero dimensions behaves as one
        apb_write(REG_DIMS, 32'd0);
        send_value(32'hFEDC_BA98, 1'b0);
        send_value(32'h0000_8000, 1'b0);
        s_valid <= 1'b0;
        wait_drained();
        // too many dimensions clamps to the maximum
        apb_write(REG_DIMS, 32'd31);
        send_value(32'h0003_0000, 1'b1);
        send_value(32'hFFFD_0000, 1'b0);
        send_value(32'h0000_0000, 1'b0);
        s_valid <= 1'b0;
        wait_drained();
        // variance off: stores are written zero
        apb_write(REG_KEEP, 32'd0);
        send_value(32'h0000_0000, 1'b1);
        send_value(32'h0000_0000, 1'b0);
        send_value(32'h7FFF_FFFF, 1'b0);
        s_valid <= 1'b0;
        wait_drained();
        // variance back on, continuing the same leaf from cleared stores
        apb_write(REG_KEEP, 32'd1);
        send_value(32'h8000_0000, 1'b0);
        send_value(32'h0001_0000, 1'b0);

        // ---- random phases: each idle pattern with and without variance ----
        for (int p = 0; p < 8; p++) begin
            s_valid <= 1'b0;
            wait_drained();
            case (p % 4)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 83;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 83;
                end
                default: begin
                    src_idle_pct   = 13;
                    sink_stall_pct = 13;
                end
            endcase
            case (p)
                0: dims_val = 1;
                1: dims_val = 16;
                2: dims_val = 0;
                3: dims_val = $urandom_range(17, 31);
                4: dims_val = 16;
                5: dims_val = 1;
                6: dims_val = $urandom_range(2, 15);
                default: dims_val = $urandom_range(0, 31);
            endcase
            apb_write(REG_KEEP, p / 4);
            apb_write(REG_DIMS, dims_val);
            sent      = 0;
            leaf_left = 0;
            while (sent < PHASE_VALUES) begin
                if (sent == PHASE_VALUES / 2) begin
                    // hold the sender until every result is back, maybe resize mid-sample
                    s_valid <= 1'b0;
                    wait_drained();
                    if ($urandom_range(1)) apb_write(REG_DIMS, $urandom_range(0, 31));
                end
                if (leaf_left == 0) begin
                    // new leaf: restart beat and a fresh center for its values
                    leaf_left = $urandom_range(1, 80);
                    center    = int'($urandom()) >>> $urandom_range(0, 31);
                    rs        = 1'b1;
                end else begin
                    // stray restart now and then breaks a sample
                    rs = ($urandom_range(99) < 3);
                end
                send_value(pick_value(center), rs);
                leaf_left--;
                sent++;
            end
        end

        // ---- drain and settle ----
        s_valid <= 1'b0;
        wait_drained();
        repeat (200) @(posedge aclk);
        if (tracker.errors == 0 && tracker.expected_stats.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
